@@ sv/bbvc_pkg.sv @@
// ----------------------------------------------------------------------------
// bbvc_pkg
// Shared widths, constants and controller/datapath handshake types of the
// basic block vector collector.
// ----------------------------------------------------------------------------
`default_nettype none

package bbvc_pkg;

  localparam int unsigned AddrW     = 64;
  localparam int unsigned CountW    = 32;
  localparam int unsigned IntervalW = 32;
  localparam int unsigned BlockIdW  = 6;
  localparam int unsigned PeriodW   = 32;
  localparam int unsigned InDataW   = 64;
  localparam int unsigned OutDataW  = 136;
  localparam int unsigned EntryW    = AddrW + CountW;

  localparam logic [PeriodW-1:0] PeriodReset = 32'd10000000;
  localparam logic [CountW-1:0]  CountMax    = '1;

  typedef struct packed {
    logic accept;
    logic blk_close;
    logic idx_clr;
    logic idx_inc;
    logic ram_rd;
    logic alloc;
    logic upd_hit;
    logic set_ovf;
    logic dump_take;
    logic dump_flush;
  } bbvc_cmd_t;

  typedef struct packed {
    logic idx_at_used;
    logic table_full;
    logic hit;
    logic cnt_nz;
    logic out_free;
    logic pend_valid;
    logic period_end;
    logic end_pending;
  } bbvc_stat_t;

  function automatic logic [CountW-1:0] bbvc_sat_add(input logic [CountW-1:0] a,
                                                      input logic [CountW-1:0] b);
    logic [CountW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CountW] ? CountMax : s[CountW-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/bbvc_ram.sv @@
// ----------------------------------------------------------------------------
// bbvc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bbvc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ sv/bbvc_ctrl.sv @@
// ----------------------------------------------------------------------------
// bbvc_ctrl
// Sequencer: takes instructions, walks the table on a branch and walks it
// to dump the vector at an interval end.
// ----------------------------------------------------------------------------
`default_nettype none

module bbvc_ctrl import bbvc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  input  wire logic       s_axis_tuser_i,
  output logic            s_axis_tready_o,
  input  wire bbvc_stat_t stat_i,
  output bbvc_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StScanRd,
    StScanCmp,
    StDumpRd,
    StDumpCmp,
    StDumpFin
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    s_axis_tready_o = (state_q == StIdle);
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid_i) begin
          cmd_o.accept  = 1'b1;
          cmd_o.idx_clr = 1'b1;
          if (s_axis_tuser_i) begin
            cmd_o.blk_close = 1'b1;
            state_d = StScanRd;
          end else if (stat_i.period_end) begin
            state_d = StDumpRd;
          end
        end
      end
      StScanRd: begin
        if (stat_i.idx_at_used) begin
          if (stat_i.table_full) begin
            cmd_o.set_ovf = 1'b1;
          end else begin
            cmd_o.alloc = 1'b1;
          end
          cmd_o.idx_clr = 1'b1;
          state_d = stat_i.end_pending ? StDumpRd : StIdle;
        end else begin
          cmd_o.ram_rd = 1'b1;
          state_d = StScanCmp;
        end
      end
      StScanCmp: begin
        if (stat_i.hit) begin
          cmd_o.upd_hit = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d = stat_i.end_pending ? StDumpRd : StIdle;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = StScanRd;
        end
      end
      StDumpRd: begin
        if (stat_i.idx_at_used) begin
          state_d = StDumpFin;
        end else begin
          cmd_o.ram_rd = 1'b1;
          state_d = StDumpCmp;
        end
      end
      StDumpCmp: begin
        if (!stat_i.cnt_nz) begin
          cmd_o.idx_inc = 1'b1;
          state_d = StDumpRd;
        end else if (!stat_i.pend_valid || stat_i.out_free) begin
          cmd_o.dump_take = 1'b1;
          cmd_o.idx_inc   = 1'b1;
          state_d = StDumpRd;
        end
      end
      StDumpFin: begin
        if (!stat_i.pend_valid || stat_i.out_free) begin
          cmd_o.dump_flush = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/bbvc_dpath.sv @@
// ----------------------------------------------------------------------------
// bbvc_dpath
// Block tracking, interval counting, entry table and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bbvc_dpath import bbvc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire bbvc_cmd_t           cmd_i,
  output bbvc_stat_t               stat_o,
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  input  wire logic                cfg_we_i,
  input  wire logic [PeriodW-1:0]  cfg_wdata_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  output logic                     m_axis_tlast_o,
  output logic                     m_axis_tuser_o
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

  logic [PeriodW-1:0]   period_q;
  logic [CountW-1:0]    insn_q;
  logic [IntervalW-1:0] interval_q;
  logic                 end_q;
  logic                 ovf_q;
  logic                 open_q;
  logic [AddrW-1:0]     start_q;
  logic [CountW-1:0]    size_q;
  logic [AddrW-1:0]     key_q;
  logic [CountW-1:0]    bsize_q;
  logic [CntW-1:0]      used_q;
  logic [CntW-1:0]      idx_q;
  logic                 pend_valid_q;
  logic [IdxW-1:0]      pend_id_q;
  logic [AddrW-1:0]     pend_addr_q;
  logic [CountW-1:0]    pend_cnt_q;
  logic                 out_valid_q;

  logic [AddrW-1:0]     start_eff;
  logic [CountW-1:0]    size_eff;
  logic [CountW-1:0]    insn_inc;
  logic                 period_end;
  logic                 out_load;
  logic                 ram_we;
  logic [EntryW-1:0]    ram_wdata;
  logic [EntryW-1:0]    ram_rdata;
  logic [AddrW-1:0]     rd_addr;
  logic [CountW-1:0]    rd_cnt;

  assign start_eff  = open_q ? start_q : s_axis_tdata_i;
  assign size_eff   = open_q ? bbvc_sat_add(size_q, CountW'(1)) : CountW'(1);
  assign insn_inc   = insn_q + CountW'(1);
  assign period_end = insn_inc >= period_q;

  assign rd_addr = ram_rdata[EntryW-1:CountW];
  assign rd_cnt  = ram_rdata[CountW-1:0];

  assign stat_o.idx_at_used = (idx_q == used_q);
  assign stat_o.table_full  = (used_q == CntW'(TABLE_ENTRIES));
  assign stat_o.hit         = (rd_addr == key_q);
  assign stat_o.cnt_nz      = (rd_cnt != '0);
  assign stat_o.out_free    = !out_valid_q || m_axis_tready_i;
  assign stat_o.pend_valid  = pend_valid_q;
  assign stat_o.period_end  = period_end;
  assign stat_o.end_pending = end_q;

  assign ram_we = cmd_i.alloc || cmd_i.upd_hit || cmd_i.dump_take;

  always_comb begin
    ram_wdata = {key_q, bsize_q};
    if (cmd_i.upd_hit) begin
      ram_wdata = {key_q, bbvc_sat_add(rd_cnt, bsize_q)};
    end else if (cmd_i.dump_take) begin
      ram_wdata = {rd_addr, {CountW{1'b0}}};
    end
  end

  bbvc_ram #(
    .Width (EntryW),
    .Depth (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q[IdxW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.ram_rd),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_load = (cmd_i.dump_take || cmd_i.dump_flush) && pend_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= PeriodReset;
      insn_q       <= '0;
      interval_q   <= '0;
      end_q        <= 1'b0;
      ovf_q        <= 1'b0;
      open_q       <= 1'b0;
      start_q      <= '0;
      size_q       <= '0;
      used_q       <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        insn_q  <= period_end ? '0 : insn_inc;
        end_q   <= period_end;
        start_q <= start_eff;
        open_q  <= !cmd_i.blk_close;
        size_q  <= size_eff;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CntW'(1);
      end
      if (cmd_i.alloc) begin
        used_q <= used_q + CntW'(1);
      end
      if (cmd_i.set_ovf) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.dump_take) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.dump_flush) begin
        pend_valid_q <= 1'b0;
        interval_q   <= interval_q + IntervalW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hand block start and size to the table walk; hold the dump entry and load the output item
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q   <= start_eff;
      bsize_q <= size_eff;
    end
    if (cmd_i.dump_take) begin
      pend_id_q   <= idx_q[IdxW-1:0];
      pend_addr_q <= rd_addr;
      pend_cnt_q  <= rd_cnt;
    end
    if (out_load) begin
      m_axis_tdata_o <= {{(OutDataW - IntervalW - BlockIdW - AddrW - CountW){1'b0}},
                         pend_cnt_q, pend_addr_q, BlockIdW'(pend_id_q), interval_q};
      m_axis_tlast_o <= cmd_i.dump_flush;
      m_axis_tuser_o <= ovf_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;

endmodule

`default_nettype wire

@@ sv/basic_block_vector_collector_unit.sv @@
// ----------------------------------------------------------------------------
// basic_block_vector_collector_unit
// Collects per-interval basic block execution counts from a retired
// instruction stream and emits the nonzero entries at each interval end.
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  s_axis    | in        | tdata: insn_address; tuser: is_branch
//  m_axis    | out       | tdata: interval, id, address, count; tlast; tuser
//  cfg       | in        | period_length, written with cfg_we_i
//
//  A non-branch instruction is accepted without a table walk. A branch walks
//  the entry table through one RAM read port, reading and comparing each
//  allocated entry in turn until a hit or the end of the used entries.
//  An interval end walks all allocated entries and waits whenever the output
//  register is still full.
//  Reset is asynchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module basic_block_vector_collector_unit import bbvc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,  // [63:0] insn_address
  input  wire logic                s_axis_tuser,  // [0] is_branch
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [31:0] interval_number, [37:32] block_id, [101:38] block_address,
  // [133:102] block_count, [135:134] zero
  output logic [OutDataW-1:0]      m_axis_tdata,
  output logic                     m_axis_tlast,
  output logic                     m_axis_tuser,  // [0] table_overflow
  input  wire logic                cfg_we_i,
  input  wire logic [PeriodW-1:0]  cfg_wdata_i
);

  bbvc_cmd_t  cmd;
  bbvc_stat_t stat;

  bbvc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tready_o (s_axis_tready),
    .stat_i          (stat),
    .cmd_o           (cmd)
  );

  bbvc_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .s_axis_tdata_i  (s_axis_tdata),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .m_axis_tuser_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

@@ sv/bbvc_checker.sv @@
// ----------------------------------------------------------------------------
// bbvc_checker
// Port-level checks of the basic block vector collector.
// ----------------------------------------------------------------------------
`default_nettype none

module bbvc_checker import bbvc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                s_axis_tuser,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata,
  input wire logic                m_axis_tlast,
  input wire logic                m_axis_tuser
);

  logic [BlockIdW-1:0] out_id;
  logic [CountW-1:0]   out_cnt;

  assign out_id  = m_axis_tdata[IntervalW +: BlockIdW];
  assign out_cnt = m_axis_tdata[IntervalW + BlockIdW + AddrW +: CountW];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

  a_branch_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("input taken during table walk");

  a_id_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(out_id) < TABLE_ENTRIES)
    else $error("block id beyond table");

  a_count_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_cnt != '0)
    else $error("zero count emitted");

endmodule

bind basic_block_vector_collector_unit bbvc_checker #(
  .TABLE_ENTRIES (TABLE_ENTRIES)
) u_bbvc_checker (.*);

`default_nettype wire
